FILE: rtl/cesh_pkg.sv
// cesh_pkg: shared types and fixed constants of the calibrated energy sum histogram
// field widths, register indexes, reset calibration, control structs
// no dependencies
`default_nettype none

package cesh_pkg;

  localparam int CHARGE_W = 16;
  localparam int GAIN_W   = 16;
  localparam int OFFSET_W = 16;
  localparam int BIN_W    = 11;
  localparam int CNT_W    = 32;
  localparam int CFG_AW   = 3;
  localparam int CFG_DW   = 16;

  // per-channel energy: Q.16 keV, product plus aligned offset
  localparam int PROD_W   = CHARGE_W + GAIN_W;
  localparam int EN_W     = PROD_W + 2;
  localparam int SUM_W    = EN_W + 2;
  localparam int OFF_SH   = 12;
  localparam int BIN_SH   = 17;

  typedef enum logic [CFG_AW-1:0] {
    REG_GAIN_A   = 3'd0,
    REG_GAIN_B   = 3'd1,
    REG_GAIN_C   = 3'd2,
    REG_OFFSET_A = 3'd3,
    REG_OFFSET_B = 3'd4,
    REG_OFFSET_C = 3'd5
  } cfg_reg_t;

  typedef enum logic {
    KIND_EVENT = 1'b0,
    KIND_READ  = 1'b1
  } kind_t;

  typedef enum logic {
    SPEC_PAIR   = 1'b0,
    SPEC_TRIPLE = 1'b1
  } spec_t;

  localparam logic [GAIN_W-1:0]   GAIN_A_RST   = 16'd4764;
  localparam logic [GAIN_W-1:0]   GAIN_B_RST   = 16'd4819;
  localparam logic [GAIN_W-1:0]   GAIN_C_RST   = 16'd4685;
  localparam logic [OFFSET_W-1:0] OFFSET_A_RST = 16'hFE81;  // -383
  localparam logic [OFFSET_W-1:0] OFFSET_B_RST = 16'hFE72;  // -398
  localparam logic [OFFSET_W-1:0] OFFSET_C_RST = 16'hFE5A;  // -422

  typedef struct packed {
    logic [GAIN_W-1:0]   gain_a;
    logic [GAIN_W-1:0]   gain_b;
    logic [GAIN_W-1:0]   gain_c;
    logic [OFFSET_W-1:0] offset_a;
    logic [OFFSET_W-1:0] offset_b;
    logic [OFFSET_W-1:0] offset_c;
  } cal_t;

  typedef struct packed {
    logic mul_en;
    logic add_en;
    logic bin_en;
  } energy_ctrl_t;

endpackage

`default_nettype wire

FILE: rtl/cesh_if.sv
// cesh channel interfaces: event/read input, result output, configuration write
// depends on cesh_pkg for field widths
`default_nettype none

interface cesh_in_if;
  logic                          valid;
  logic                          ready;
  logic                          kind;
  logic [cesh_pkg::CHARGE_W-1:0] charge_a;
  logic [cesh_pkg::CHARGE_W-1:0] charge_b;
  logic [cesh_pkg::CHARGE_W-1:0] charge_c;
  logic                          spectrum_select;
  logic [cesh_pkg::BIN_W-1:0]    bin_index;

  modport source (output valid, kind, charge_a, charge_b, charge_c, spectrum_select,
                  bin_index, input ready);
  modport sink   (input valid, kind, charge_a, charge_b, charge_c, spectrum_select,
                  bin_index, output ready);
endinterface

interface cesh_out_if;
  logic                       valid;
  logic                       ready;
  logic [cesh_pkg::BIN_W-1:0] pair_bin;
  logic [cesh_pkg::BIN_W-1:0] triple_bin;
  logic [cesh_pkg::CNT_W-1:0] bin_count;

  modport source (output valid, pair_bin, triple_bin, bin_count, input ready);
  modport sink   (input valid, pair_bin, triple_bin, bin_count, output ready);
endinterface

interface cesh_cfg_if;
  logic                        valid;
  logic                        ready;
  logic [cesh_pkg::CFG_AW-1:0] addr;
  logic [cesh_pkg::CFG_DW-1:0] data;

  modport source (output valid, addr, data, input ready);
  modport sink   (input valid, addr, data, output ready);
endinterface

`default_nettype wire

FILE: rtl/cesh_ram.sv
// cesh_ram: generic simple dual-port ram, one write and one registered read port
// no dependencies
`default_nettype none

module cesh_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1026
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    // read data holds while no read is issued
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

FILE: rtl/cesh_energy.sv
// cesh_energy: calibration and binning datapath, multiply, add offset, sum and bin
// depends on cesh_pkg (cal_t, energy_ctrl_t, widths)
`default_nettype none

module cesh_energy #(
  parameter int NUM_BINS = 1024,
  localparam int AW = $clog2(NUM_BINS + 2)
) (
  input  wire logic                          clk,
  input  wire cesh_pkg::energy_ctrl_t        ctrl,
  input  wire cesh_pkg::cal_t                cal,
  input  wire logic [cesh_pkg::CHARGE_W-1:0] charge_a,
  input  wire logic [cesh_pkg::CHARGE_W-1:0] charge_b,
  input  wire logic [cesh_pkg::CHARGE_W-1:0] charge_c,
  output      logic [AW-1:0]                 pair_bin,
  output      logic [AW-1:0]                 triple_bin
);

  localparam int PW = cesh_pkg::PROD_W;
  localparam int EW = cesh_pkg::EN_W;
  localparam int SW = cesh_pkg::SUM_W;
  localparam int HW = SW - cesh_pkg::BIN_SH;
  localparam int OW = cesh_pkg::OFFSET_W;
  localparam int SH = cesh_pkg::OFF_SH;
  localparam logic [HW-1:0] NB        = HW'(NUM_BINS);
  localparam logic [AW-1:0] UNDER_BIN = AW'(NUM_BINS);
  localparam logic [AW-1:0] OVER_BIN  = AW'(NUM_BINS + 1);

  logic [PW-1:0] prod_a_r, prod_b_r, prod_c_r;
  logic [EW-1:0] en_a_r, en_b_r, en_c_r;
  logic [EW-1:0] en_a_nxt, en_b_nxt, en_c_nxt;
  logic [SW-1:0] pair_sum, triple_sum;
  logic [AW-1:0] pair_bin_r, triple_bin_r;
  logic [AW-1:0] pair_bin_nxt, triple_bin_nxt;

  function automatic logic [EW-1:0] add_offset(input logic [PW-1:0] p,
                                                 input logic [OW-1:0] o);
    logic [EW-1:0] ext;
    ext = {{(EW - OW - SH){o[OW-1]}}, o, {SH{1'b0}}};
    return {2'b00, p} + ext;
  endfunction

  function automatic logic [AW-1:0] bin_of(input logic [SW-1:0] s);
    logic [HW-1:0] hi;
    hi = s[SW-1:cesh_pkg::BIN_SH];
    if (s[SW-1]) begin
      return UNDER_BIN;
    end else if (hi >= NB) begin
      return OVER_BIN;
    end
    return AW'(hi);
  endfunction

  always_comb begin
    en_a_nxt       = add_offset(prod_a_r, cal.offset_a);
    en_b_nxt       = add_offset(prod_b_r, cal.offset_b);
    en_c_nxt       = add_offset(prod_c_r, cal.offset_c);
    pair_sum       = {{2{en_a_r[EW-1]}}, en_a_r} + {{2{en_b_r[EW-1]}}, en_b_r};
    triple_sum     = pair_sum + {{2{en_c_r[EW-1]}}, en_c_r};
    pair_bin_nxt   = bin_of(pair_sum);
    triple_bin_nxt = bin_of(triple_sum);
  end

  always_ff @(posedge clk) begin
    if (ctrl.mul_en) begin
      prod_a_r <= charge_a * cal.gain_a;
      prod_b_r <= charge_b * cal.gain_b;
      prod_c_r <= charge_c * cal.gain_c;
    end
    if (ctrl.add_en) begin
      en_a_r <= en_a_nxt;
      en_b_r <= en_b_nxt;
      en_c_r <= en_c_nxt;
    end
    if (ctrl.bin_en) begin
      pair_bin_r   <= pair_bin_nxt;
      triple_bin_r <= triple_bin_nxt;
    end
  end

  assign pair_bin   = pair_bin_r;
  assign triple_bin = triple_bin_r;

endmodule

`default_nettype wire

FILE: rtl/calibrated_energy_sum_histogram_core.sv
// calibrated energy sum histogram: pair-sum and triple-sum spectra in two rams
// event: multiply, add, bin, ram read and write-back states; result loads on leaving write-back
// read: ram read and write-back states; write-back waits for a free result slot
// no new transaction until idle; the item sequencer and the spectrum read-modify-write set the rate
// reset: synchronous active-low rst_n; a clearing pass over all NUM_BINS+2 bins follows
// (1026 at the default), in which only configuration writes are taken
`default_nettype none

module calibrated_energy_sum_histogram_core #(
  parameter int NUM_BINS    = 1024,
  parameter int COUNT_WIDTH = 32
) (
  input wire logic  clk,
  input wire logic  rst_n,
  cesh_in_if.sink   in_ch,
  cesh_out_if.source out_ch,
  cesh_cfg_if.sink  cfg_ch
);

  localparam int TOTAL = NUM_BINS + 2;
  localparam int AW    = $clog2(TOTAL);
  localparam int BW    = cesh_pkg::BIN_W;
  localparam int CW    = cesh_pkg::CNT_W;
  localparam int IXW   = ((AW > BW) ? AW : BW) + 1;
  localparam logic [AW-1:0]  LAST_ADDR = AW'(TOTAL - 1);
  localparam logic [IXW-1:0] TOTAL_IX  = IXW'(TOTAL);

  // sequencer states, one-hot
  typedef enum logic [6:0] {
    ST_CLEAR = 7'b0000001,
    ST_IDLE  = 7'b0000010,
    ST_MUL   = 7'b0000100,
    ST_ADD   = 7'b0001000,
    ST_BIN   = 7'b0010000,
    ST_READ  = 7'b0100000,
    ST_WRITE = 7'b1000000
  } state_t;

  state_t                        state_r, state_nxt;
  logic [AW-1:0]                 clr_addr_r, clr_addr_nxt;
  cesh_pkg::cal_t                cal_r, cal_nxt;

  // held transaction fields
  cesh_pkg::kind_t               kind_r;
  cesh_pkg::spec_t               sel_r;
  logic [cesh_pkg::CHARGE_W-1:0] charge_a_r, charge_b_r, charge_c_r;
  logic [AW-1:0]                 rd_addr_r;
  logic                          idx_ok_r;

  // result register, parts the output side from the sequencer
  logic                          out_valid_r, out_valid_nxt;
  logic [BW-1:0]                 out_pair_r, out_triple_r;
  logic [CW-1:0]                 out_count_r;

  logic                          in_acc;
  logic                          slot_free;
  cesh_pkg::energy_ctrl_t        ectrl;
  logic [AW-1:0]                 pair_bin, triple_bin;

  // spectrum ram ports
  logic                          mem_re;
  logic                          mem_we;
  logic [AW-1:0]                 pair_raddr, triple_raddr;
  logic [AW-1:0]                 pair_waddr, triple_waddr;
  logic [COUNT_WIDTH-1:0]        pair_rdata, triple_rdata;
  logic [COUNT_WIDTH-1:0]        pair_wdata, triple_wdata;
  logic [COUNT_WIDTH-1:0]        pair_inc, triple_inc;
  logic [COUNT_WIDTH-1:0]        sel_count;

  assign in_ch.ready  = (state_r == ST_IDLE);
  assign cfg_ch.ready = 1'b1;
  assign in_acc       = in_ch.valid && in_ch.ready;
  assign slot_free    = !out_valid_r || out_ch.ready;

  // calibration datapath, stepped by the sequencer
  assign ectrl.mul_en = (state_r == ST_MUL);
  assign ectrl.add_en = (state_r == ST_ADD);
  assign ectrl.bin_en = (state_r == ST_BIN);

  cesh_energy #(
    .NUM_BINS (NUM_BINS)
  ) u_energy (
    .clk        (clk),
    .ctrl       (ectrl),
    .cal        (cal_r),
    .charge_a   (charge_a_r),
    .charge_b   (charge_b_r),
    .charge_c   (charge_c_r),
    .pair_bin   (pair_bin),
    .triple_bin (triple_bin)
  );

  // saturating increments of the bins just read
  assign pair_inc   = (pair_rdata == '1)   ? pair_rdata   : pair_rdata + 1'b1;
  assign triple_inc = (triple_rdata == '1) ? triple_rdata : triple_rdata + 1'b1;
  assign sel_count  = (sel_r == cesh_pkg::SPEC_TRIPLE) ? triple_rdata : pair_rdata;

  always_comb begin
    // read port: bins of the event, or the requested bin of a read transaction
    mem_re       = (state_r == ST_READ);
    pair_raddr   = (kind_r == cesh_pkg::KIND_EVENT) ? pair_bin   : rd_addr_r;
    triple_raddr = (kind_r == cesh_pkg::KIND_EVENT) ? triple_bin : rd_addr_r;

    // write port: clearing sweep, or write-back once the result slot is free
    if (state_r == ST_CLEAR) begin
      mem_we       = 1'b1;
      pair_waddr   = clr_addr_r;
      triple_waddr = clr_addr_r;
      pair_wdata   = '0;
      triple_wdata = '0;
    end else begin
      mem_we       = (state_r == ST_WRITE) && (kind_r == cesh_pkg::KIND_EVENT) && slot_free;
      pair_waddr   = pair_bin;
      triple_waddr = triple_bin;
      pair_wdata   = pair_inc;
      triple_wdata = triple_inc;
    end
  end

  cesh_ram #(
    .WIDTH (COUNT_WIDTH),
    .DEPTH (TOTAL)
  ) u_pair_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (pair_waddr),
    .wdata (pair_wdata),
    .re    (mem_re),
    .raddr (pair_raddr),
    .rdata (pair_rdata)
  );

  cesh_ram #(
    .WIDTH (COUNT_WIDTH),
    .DEPTH (TOTAL)
  ) u_triple_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (triple_waddr),
    .wdata (triple_wdata),
    .re    (mem_re),
    .raddr (triple_raddr),
    .rdata (triple_rdata)
  );

  // sequencer
  always_comb begin
    state_nxt    = state_r;
    clr_addr_nxt = clr_addr_r;
    case (state_r)
      ST_CLEAR: begin
        clr_addr_nxt = clr_addr_r + 1'b1;
        if (clr_addr_r == LAST_ADDR) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_acc) begin
          state_nxt = (in_ch.kind == cesh_pkg::KIND_EVENT) ? ST_MUL : ST_READ;
        end
      end
      ST_MUL:   state_nxt = ST_ADD;
      ST_ADD:   state_nxt = ST_BIN;
      ST_BIN:   state_nxt = ST_READ;
      ST_READ:  state_nxt = ST_WRITE;
      ST_WRITE: begin
        if (slot_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default:  state_nxt = ST_CLEAR;
    endcase
  end

  // result register handshake
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
    if ((state_r == ST_WRITE) && slot_free) begin
      out_valid_nxt = 1'b1;
    end
  end

  // configuration writes, unknown indexes ignored
  always_comb begin
    cal_nxt = cal_r;
    if (cfg_ch.valid && cfg_ch.ready) begin
      case (cesh_pkg::cfg_reg_t'(cfg_ch.addr))
        cesh_pkg::REG_GAIN_A:   cal_nxt.gain_a   = cfg_ch.data;
        cesh_pkg::REG_GAIN_B:   cal_nxt.gain_b   = cfg_ch.data;
        cesh_pkg::REG_GAIN_C:   cal_nxt.gain_c   = cfg_ch.data;
        cesh_pkg::REG_OFFSET_A: cal_nxt.offset_a = cfg_ch.data;
        cesh_pkg::REG_OFFSET_B: cal_nxt.offset_b = cfg_ch.data;
        cesh_pkg::REG_OFFSET_C: cal_nxt.offset_c = cfg_ch.data;
        default:                cal_nxt          = cal_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= ST_CLEAR;
      clr_addr_r     <= '0;
      out_valid_r    <= 1'b0;
      cal_r.gain_a   <= cesh_pkg::GAIN_A_RST;
      cal_r.gain_b   <= cesh_pkg::GAIN_B_RST;
      cal_r.gain_c   <= cesh_pkg::GAIN_C_RST;
      cal_r.offset_a <= cesh_pkg::OFFSET_A_RST;
      cal_r.offset_b <= cesh_pkg::OFFSET_B_RST;
      cal_r.offset_c <= cesh_pkg::OFFSET_C_RST;
    end else begin
      state_r     <= state_nxt;
      clr_addr_r  <= clr_addr_nxt;
      out_valid_r <= out_valid_nxt;
      cal_r       <= cal_nxt;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    if (in_acc) begin
      kind_r     <= cesh_pkg::kind_t'(in_ch.kind);
      sel_r      <= cesh_pkg::spec_t'(in_ch.spectrum_select);
      charge_a_r <= in_ch.charge_a;
      charge_b_r <= in_ch.charge_b;
      charge_c_r <= in_ch.charge_c;
      rd_addr_r  <= AW'(in_ch.bin_index);
      idx_ok_r   <= IXW'(in_ch.bin_index) < TOTAL_IX;
    end
    if ((state_r == ST_WRITE) && slot_free) begin
      if (kind_r == cesh_pkg::KIND_EVENT) begin
        out_pair_r   <= BW'(pair_bin);
        out_triple_r <= BW'(triple_bin);
        out_count_r  <= '0;
      end else begin
        out_pair_r   <= '0;
        out_triple_r <= '0;
        // out-of-range bin index reads as zero
        out_count_r  <= idx_ok_r ? CW'(sel_count) : '0;
      end
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.pair_bin   = out_pair_r;
  assign out_ch.triple_bin = out_triple_r;
  assign out_ch.bin_count  = out_count_r;

`ifndef SYNTHESIS
  // spectrum writes stay inside the bin range
  a_waddr_range: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> (IXW'(pair_waddr) < TOTAL_IX) && (IXW'(triple_waddr) < TOTAL_IX))
    else $error("spectrum write address out of range");

  // a result appears only after the write-back step
  a_result_from_write: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_WRITE))
    else $error("result raised outside write-back");

  // counts never wrap on write-back
  a_no_wrap: assert property (@(posedge clk) disable iff (!rst_n)
    (mem_we && (state_r == ST_WRITE)) |->
      (pair_wdata >= pair_rdata) && (triple_wdata >= triple_rdata))
    else $error("spectrum count wrapped");

  // no transaction is taken while the clearing pass runs
  a_clear_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CLEAR) |=> !$past(in_acc))
    else $error("transaction accepted during clearing pass");
`endif

endmodule

`default_nettype wire

FILE: tb/sv/tb_calibrated_energy_sum_histogram_core.sv
// testbench for calibrated_energy_sum_histogram_core: a directed table, then random event and
// read traffic over several calibrations, checked against a local spectrum predictor
// depends on cesh_pkg and the cesh channel interfaces
module tb_calibrated_energy_sum_histogram_core;
  import cesh_pkg::*;

  localparam int SPEC_BINS   = 1024;
  localparam int UNDER_BIN   = SPEC_BINS;
  localparam int OVER_BIN    = SPEC_BINS + 1;
  localparam int CYCLE_LIMIT = 600000;
  localparam int HIT_DEPTH   = 32;
  // register indexes past the calibration set, which the block must ignore
  localparam logic [CFG_AW-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [CFG_AW-1:0] REG_SPARE_HI = 3'd7;

  typedef struct packed {
    logic [BIN_W-1:0] pair_bin;
    logic [BIN_W-1:0] triple_bin;
    logic [CNT_W-1:0] bin_count;
  } result_t;

  // one input transaction; typed rows carry a hand-written result
  typedef struct {
    kind_t               kind;
    logic [CHARGE_W-1:0] qa;
    logic [CHARGE_W-1:0] qb;
    logic [CHARGE_W-1:0] qc;
    spec_t               sel;
    logic [BIN_W-1:0]    idx;
    bit                  typed;
    result_t             want;
  } work_item_t;

  logic clk;
  logic rst_n;

  cesh_in_if  in_bus ();
  cesh_out_if res_bus ();
  cesh_cfg_if cfg_bus ();

  calibrated_energy_sum_histogram_core #(
    .NUM_BINS   (SPEC_BINS),
    .COUNT_WIDTH(CNT_W)
  ) uut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_bus),
    .out_ch(res_bus),
    .cfg_ch(cfg_bus)
  );

  // predictor state: calibration copy and both spectra
  logic [GAIN_W-1:0]   cal_gain_a, cal_gain_b, cal_gain_c;
  logic [OFFSET_W-1:0] cal_off_a, cal_off_b, cal_off_c;
  logic [CNT_W-1:0]    pair_counts   [SPEC_BINS+2];
  logic [CNT_W-1:0]    triple_counts [SPEC_BINS+2];

  result_t          awaited_results [$];
  logic [BIN_W-1:0] pair_hits [$];
  logic [BIN_W-1:0] triple_hits [$];
  work_item_t       last_event;
  bit               have_last_event;

  int      fail_count;
  int      results_seen;
  int      cycle_count;
  int      sink_stall_left;
  int      sink_quiet_left;
  bit      long_hold_done;
  bit      burst_mode;
  result_t head;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // run limit, generous against the slowest legal run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("calibrated_energy_sum_histogram_core: mismatch");
      $finish;
    end
  end

  // ---------------------------------------------------------------- predictor

  // channel energy in q.16 kev: charge times gain plus the q11.4 offset aligned up
  function automatic longint energy_q16(logic [15:0] q, logic [15:0] g, logic [15:0] off);
    return longint'(q) * longint'(g) + longint'($signed(off)) * 4096;
  endfunction

  // 2 kev bins; negative sums to underflow, at or past the top to overflow
  function automatic logic [BIN_W-1:0] bin_for(longint e);
    if (e < 0) return BIN_W'(UNDER_BIN);
    if ((e >>> BIN_SH) >= SPEC_BINS) return BIN_W'(OVER_BIN);
    return BIN_W'(e >>> BIN_SH);
  endfunction

  // applies one transaction to the spectra and returns the result it must produce
  function automatic result_t histogram_update(work_item_t it);
    result_t r;
    longint  ea, eb, ec;
    r = '0;
    if (it.kind == KIND_EVENT) begin
      ea = energy_q16(it.qa, cal_gain_a, cal_off_a);
      eb = energy_q16(it.qb, cal_gain_b, cal_off_b);
      ec = energy_q16(it.qc, cal_gain_c, cal_off_c);
      r.pair_bin   = bin_for(ea + eb);
      r.triple_bin = bin_for(ea + eb + ec);
      // counters stick at all ones
      if (pair_counts[r.pair_bin] != '1) pair_counts[r.pair_bin]++;
      if (triple_counts[r.triple_bin] != '1) triple_counts[r.triple_bin]++;
    end else if (it.idx < SPEC_BINS + 2) begin
      r.bin_count = (it.sel == SPEC_TRIPLE) ? triple_counts[it.idx] : pair_counts[it.idx];
    end
    return r;
  endfunction

  // ---------------------------------------------------------------- stimulus helpers

  // idle length: mostly none or short, now and then long
  function automatic int idle_span();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(25, 70);
  endfunction

  // charge that puts the channel somewhere between 0 and 800 kev under the current calibration
  function automatic logic [15:0] shaped_charge(logic [15:0] g, logic [15:0] off);
    longint target, q;
    target = longint'($urandom_range(0, 800 * 65536));
    if (g == 0) return 16'($urandom);
    q = (target - longint'($signed(off)) * 4096) / longint'(g);
    if (q < 0) return 16'd0;
    if (q > 65535) return 16'hFFFF;
    return 16'(q);
  endfunction

  function automatic work_item_t draw_item(bit near_edges);
    work_item_t it;
    int         r;
    it = '{KIND_EVENT, 16'($urandom), 16'($urandom), 16'($urandom), spec_t'($urandom_range(0, 1)),
           BIN_W'($urandom), 1'b0, '0};
    if ($urandom_range(0, 99) < 30) begin
      it.kind = KIND_READ;
      r = $urandom_range(0, 99);
      // mostly bins that have been hit, so counts come back non-zero
      if (r < 55 && it.sel == SPEC_PAIR && pair_hits.size() != 0)
        it.idx = pair_hits[$urandom_range(0, pair_hits.size() - 1)];
      else if (r < 55 && it.sel == SPEC_TRIPLE && triple_hits.size() != 0)
        it.idx = triple_hits[$urandom_range(0, triple_hits.size() - 1)];
      else if (r < 75) it.idx = BIN_W'($urandom_range(0, SPEC_BINS + 1));
      else if (r < 88) it.idx = BIN_W'($urandom_range(UNDER_BIN, OVER_BIN));
      // anything the field holds, past the overflow bin included
      else it.idx = BIN_W'($urandom_range(0, 2047));
      return it;
    end
    r = $urandom_range(0, 99);
    if (have_last_event && r < 15) begin
      // same event again, back to back on the same bins
      it = last_event;
    end else if (near_edges && r < 50) begin
      it.qa = ($urandom_range(0, 1) == 1) ? 16'($urandom_range(4088, 4104))
                                          : 16'($urandom_range(0, 3));
    end else if (r < 85) begin
      it.qa = shaped_charge(cal_gain_a, cal_off_a);
      it.qb = shaped_charge(cal_gain_b, cal_off_b);
      it.qc = shaped_charge(cal_gain_c, cal_off_c);
    end
    last_event      = it;
    have_last_event = 1'b1;
    return it;
  endfunction

  // ---------------------------------------------------------------- drivers

  // offers one transaction and books its expected result on acceptance
  task automatic send_item(input work_item_t it);
    result_t want;
    @(negedge clk);
    in_bus.valid           = 1'b1;
    in_bus.kind            = it.kind;
    in_bus.charge_a        = it.qa;
    in_bus.charge_b        = it.qb;
    in_bus.charge_c        = it.qc;
    in_bus.spectrum_select = it.sel;
    in_bus.bin_index       = it.idx;
    do @(posedge clk); while (!in_bus.ready);
    want = histogram_update(it);
    awaited_results.push_back(it.typed ? it.want : want);
    if (it.kind == KIND_EVENT) begin
      pair_hits.push_back(want.pair_bin);
      triple_hits.push_back(want.triple_bin);
      if (pair_hits.size() > HIT_DEPTH) void'(pair_hits.pop_front());
      if (triple_hits.size() > HIT_DEPTH) void'(triple_hits.pop_front());
    end
  endtask

  // holds valid low before the next offer; n sets the length of the gap, none for zero
  task automatic pause_input(input int n);
    if (n > 0) begin
      @(negedge clk);
      in_bus.valid = 1'b0;
      repeat (n - 1) @(negedge clk);
    end
  endtask

  task automatic run_random(input int count, input bit near_edges);
    for (int i = 0; i < count; i++) begin
      // alternate gappy and back-to-back stretches
      if (i % 64 == 0) burst_mode = ($urandom_range(0, 3) == 0);
      send_item(draw_item(near_edges));
      pause_input(burst_mode ? 0 : idle_span());
    end
  endtask

  // every transaction yields a result, so an empty queue means the pipeline is idle
  task automatic drain_results();
    @(negedge clk);
    in_bus.valid = 1'b0;
    while (awaited_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_AW-1:0] addr, input logic [CFG_DW-1:0] value);
    @(negedge clk);
    cfg_bus.valid = 1'b1;
    cfg_bus.addr  = addr;
    cfg_bus.data  = value;
    do @(posedge clk); while (!cfg_bus.ready);
    case (addr)
      REG_GAIN_A:   cal_gain_a = value;
      REG_GAIN_B:   cal_gain_b = value;
      REG_GAIN_C:   cal_gain_c = value;
      REG_OFFSET_A: cal_off_a  = value;
      REG_OFFSET_B: cal_off_b  = value;
      REG_OFFSET_C: cal_off_c  = value;
      default: ;
    endcase
    @(negedge clk);
    cfg_bus.valid = 1'b0;
  endtask

  task automatic write_calibration(input logic [15:0] ga, gb, gc, oa, ob, oc);
    write_reg(REG_GAIN_A, ga);
    write_reg(REG_GAIN_B, gb);
    write_reg(REG_GAIN_C, gc);
    write_reg(REG_OFFSET_A, oa);
    write_reg(REG_OFFSET_B, ob);
    write_reg(REG_OFFSET_C, oc);
  endtask

  // ---------------------------------------------------------------- result side

  // ready pattern: random stalls, quiet stretches, and one long hold-off that
  // lets the block fill up while the sender keeps offering
  initial begin
    res_bus.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (!long_hold_done && results_seen >= 350) begin
        sink_stall_left = 400;
        long_hold_done  = 1'b1;
      end
      if (sink_stall_left > 0) begin
        res_bus.ready = 1'b0;
        sink_stall_left--;
      end else begin
        res_bus.ready = 1'b1;
        if (sink_quiet_left > 0) begin
          sink_quiet_left--;
        end else begin
          sink_stall_left = idle_span();
          if ($urandom_range(0, 199) == 0) sink_quiet_left = $urandom_range(100, 300);
        end
      end
    end
  end

  function automatic void field_check(string name, longint unsigned want, longint unsigned got);
    if (want != got) begin
      $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
      fail_count++;
    end
  endfunction

  always @(posedge clk) begin
    if (rst_n && res_bus.valid && res_bus.ready) begin
      results_seen++;
      if (awaited_results.size() == 0) begin
        $display("%0t: unexpected result, expected none, got pair %0d triple %0d count %0d",
                 $time, res_bus.pair_bin, res_bus.triple_bin, res_bus.bin_count);
        fail_count++;
      end else begin
        head = awaited_results.pop_front();
        field_check("pair_bin", head.pair_bin, res_bus.pair_bin);
        field_check("triple_bin", head.triple_bin, res_bus.triple_bin);
        field_check("bin_count", head.bin_count, res_bus.bin_count);
      end
    end
  end

  // ---------------------------------------------------------------- sequence

  work_item_t directed_rows [$];

  initial begin
    rst_n                  = 1'b0;
    in_bus.valid           = 1'b0;
    in_bus.kind            = KIND_EVENT;
    in_bus.charge_a        = '0;
    in_bus.charge_b        = '0;
    in_bus.charge_c        = '0;
    in_bus.spectrum_select = SPEC_PAIR;
    in_bus.bin_index       = '0;
    cfg_bus.valid          = 1'b0;
    cfg_bus.addr           = REG_GAIN_A;
    cfg_bus.data           = '0;
    fail_count             = 0;
    results_seen           = 0;
    cycle_count            = 0;
    sink_stall_left        = 0;
    sink_quiet_left        = 0;
    long_hold_done         = 1'b0;
    burst_mode             = 1'b0;
    have_last_event        = 1'b0;
    cal_gain_a = GAIN_A_RST;
    cal_gain_b = GAIN_B_RST;
    cal_gain_c = GAIN_C_RST;
    cal_off_a  = OFFSET_A_RST;
    cal_off_b  = OFFSET_B_RST;
    cal_off_c  = OFFSET_C_RST;
    for (int b = 0; b < SPEC_BINS + 2; b++) begin
      pair_counts[b]   = '0;
      triple_counts[b] = '0;
    end

    // directed table, at the reset calibration; typed rows are obvious by inspection
    // empty spectra read back zero, including the out-of-range index
    directed_rows.push_back('{KIND_READ, 16'd0, 16'd0, 16'd0, SPEC_PAIR, 11'd0, 1, '0});
    directed_rows.push_back('{KIND_READ, 16'hFFFF, 16'hFFFF, 16'hFFFF, SPEC_TRIPLE,
                              11'(OVER_BIN), 1, '0});
    directed_rows.push_back('{KIND_READ, 16'd0, 16'd0, 16'd0, SPEC_PAIR, 11'd2047, 1, '0});
    directed_rows.push_back('{KIND_READ, 16'd0, 16'd0, 16'd0, SPEC_TRIPLE, 11'd1026, 1, '0});
    // zero charge: negative offsets only, so both sums underflow
    directed_rows.push_back('{KIND_EVENT, 16'd0, 16'd0, 16'd0, SPEC_PAIR, 11'd0, 1,
                              '{11'(UNDER_BIN), 11'(UNDER_BIN), 32'd0}});
    // full-scale charges land far past the top bin
    directed_rows.push_back('{KIND_EVENT, 16'hFFFF, 16'hFFFF, 16'hFFFF, SPEC_PAIR, 11'd0, 1,
                              '{11'(OVER_BIN), 11'(OVER_BIN), 32'd0}});
    directed_rows.push_back('{KIND_READ, 16'd0, 16'd0, 16'd0, SPEC_PAIR, 11'(UNDER_BIN), 1,
                              '{11'd0, 11'd0, 32'd1}});
    directed_rows.push_back('{KIND_READ, 16'd0, 16'd0, 16'd0, SPEC_TRIPLE, 11'(OVER_BIN), 1,
                              '{11'd0, 11'd0, 32'd1}});
    directed_rows.push_back('{KIND_READ, 16'd0, 16'd0, 16'd0, SPEC_PAIR, 11'(OVER_BIN), 1,
                              '{11'd0, 11'd0, 32'd1}});
    // mid-range events, twice in a row, then read straight back
    directed_rows.push_back('{KIND_EVENT, 16'd6000, 16'd6000, 16'd6000, SPEC_PAIR, 11'd0, 0, '0});
    directed_rows.push_back('{KIND_EVENT, 16'd6000, 16'd6000, 16'd6000, SPEC_PAIR, 11'd0, 0, '0});
    directed_rows.push_back('{KIND_READ, 16'd0, 16'd0, 16'd0, SPEC_PAIR, 11'd414, 0, '0});
    directed_rows.push_back('{KIND_READ, 16'd0, 16'd0, 16'd0, SPEC_TRIPLE, 11'd615, 0, '0});
    // pair in range with triple over, then pair under with triple in range
    directed_rows.push_back('{KIND_EVENT, 16'd6000, 16'd6000, 16'hFFFF, SPEC_PAIR, 11'd0, 0, '0});
    directed_rows.push_back('{KIND_EVENT, 16'd0, 16'd0, 16'd20000, SPEC_PAIR, 11'd0, 0, '0});
    directed_rows.push_back('{KIND_READ, 16'd0, 16'd0, 16'd0, SPEC_TRIPLE, 11'(UNDER_BIN), 0, '0});
    directed_rows.push_back('{KIND_EVENT, 16'd0, 16'd0, 16'd0, SPEC_PAIR, 11'd0, 1,
                              '{11'(UNDER_BIN), 11'(UNDER_BIN), 32'd0}});
    directed_rows.push_back('{KIND_READ, 16'd0, 16'd0, 16'd0, SPEC_PAIR, 11'(UNDER_BIN), 0, '0});
    directed_rows.push_back('{KIND_EVENT, 16'hFFFF, 16'd0, 16'd0, SPEC_PAIR, 11'd0, 0, '0});
    directed_rows.push_back('{KIND_READ, 16'hFFFF, 16'hFFFF, 16'hFFFF, SPEC_TRIPLE, 11'd2047, 1,
                              '0});
    directed_rows.push_back('{KIND_EVENT, 16'hAAAA, 16'h5555, 16'h0F0F, SPEC_PAIR, 11'd0, 0, '0});
    directed_rows.push_back('{KIND_READ, 16'd0, 16'd0, 16'd0, SPEC_TRIPLE, 11'd1023, 0, '0});

    repeat (12) @(negedge clk);
    rst_n = 1'b1;

    // the block clears its spectra first; the first handshake waits it out
    foreach (directed_rows[i]) begin
      send_item(directed_rows[i]);
      pause_input(idle_span());
    end
    // sender waits here for every outstanding result
    drain_results();
    run_random(200, 1'b0);

    // moderate random calibration; the long receiver hold-off falls in this phase
    drain_results();
    write_calibration(16'($urandom_range(2000, 20000)), 16'($urandom_range(2000, 20000)),
                      16'($urandom_range(2000, 20000)), 16'(-$urandom_range(0, 800)),
                      16'(-$urandom_range(0, 800)), 16'($urandom_range(0, 800)));
    run_random(220, 1'b0);

    // full gain with the most negative offsets
    drain_results();
    write_calibration(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h8000, 16'h8000, 16'h8000);
    run_random(150, 1'b0);

    // zero gain, offsets at both extremes: pair just below zero, triple in the top bin
    drain_results();
    write_calibration(16'd0, 16'd0, 16'd0, 16'h7FFF, 16'h8000, 16'h7FFF);
    run_random(40, 1'b1);

    // half a kev per unit on channel a only, so charge 4096 sits on the top edge
    // and a small negative channel c offset puts triple zero just under
    drain_results();
    write_calibration(16'h8000, 16'd0, 16'd0, 16'd0, 16'd0, 16'hFFFF);
    write_reg(REG_SPARE_LO, 16'($urandom));
    write_reg(REG_SPARE_HI, 16'($urandom));
    run_random(260, 1'b1);

    // anything goes
    drain_results();
    write_calibration(16'($urandom), 16'($urandom), 16'($urandom),
                      16'($urandom), 16'($urandom), 16'($urandom));
    run_random(270, 1'b0);

    drain_results();
    repeat (30) @(posedge clk);
    if (fail_count == 0) begin
      $display("calibrated_energy_sum_histogram_core: match");
    end else begin
      $display("calibrated_energy_sum_histogram_core: mismatch");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/cesh_pkg.sv
rtl/cesh_if.sv
rtl/cesh_ram.sv
rtl/cesh_energy.sv
rtl/calibrated_energy_sum_histogram_core.sv
tb/sv/tb_calibrated_energy_sum_histogram_core.sv
